[src/acc_pkg.sv]
// Shared constants, types and AES helper functions for the CBC/CMAC block.
package acc_pkg;

    localparam int KeyWords = 22;
    localparam int KeyAw    = 5;
    localparam logic [7:0] CmacRb = 8'h87;
    localparam int SignBit    = 0;
    localparam int EncryptBit = 1;

    typedef logic [7:0] byte_t;

    // Result word handed from the core to the output register.
    typedef struct packed {
        logic         kind;
        logic [127:0] data;
        logic         last;
    } res_t;

    function automatic byte_t sbox(input byte_t x);
        byte_t t [256];
        t = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        return t[x];
    endfunction

    function automatic byte_t xtime(input byte_t x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
    endfunction

    // One AES round without the key add; byte 0 is the top byte.
    function automatic logic [127:0] aes_round(input logic [127:0] s, input logic final_rnd);
        byte_t b [16];
        byte_t t [16];
        byte_t a0, a1, a2, a3, al;
        logic [127:0] o;
        for (int i = 0; i < 16; i++) b[i] = sbox(s[127-8*i -: 8]);
        for (int c = 0; c < 4; c++)
            for (int i = 0; i < 4; i++)
                t[i+4*c] = b[i + 4*((c+i) & 3)];
        if (!final_rnd)
        begin
            for (int c = 0; c < 4; c++)
            begin
                a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
                al = a0 ^ a1 ^ a2 ^ a3;
                t[4*c]   = a0 ^ al ^ xtime(a0 ^ a1);
                t[4*c+1] = a1 ^ al ^ xtime(a1 ^ a2);
                t[4*c+2] = a2 ^ al ^ xtime(a2 ^ a3);
                t[4*c+3] = a3 ^ al ^ xtime(a3 ^ a0);
            end
        end
        for (int i = 0; i < 16; i++) o[127-8*i -: 8] = t[i];
        return o;
    endfunction

endpackage

[src/acc_key_ram.sv]
// Round key memory: 22 words of 64 bits, one write and one registered read port.
module acc_key_ram
    import acc_pkg::*;
(
    input  logic             clk,
    input  logic             we,
    input  logic [KeyAw-1:0] waddr,
    input  logic [63:0]      wdata,
    input  logic [KeyAw-1:0] raddr,
    output logic [63:0]      rdata
);

    logic [63:0] mem [KeyWords];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

[src/acc_core.sv]
// Sequencer: key expansion into the key memory, iterative AES rounds, CBC and CMAC.
module acc_core
    import acc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic [127:0] key,
    input  logic [1:0]   mode,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [127:0] in_data,
    input  logic         in_last,
    output logic         res_valid,
    input  logic         res_ready,
    output res_t         res
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_KEXP  = 8'b0000_0010,
        S_LOAD  = 8'b0000_0100,
        S_RND   = 8'b0000_1000,
        S_DONE  = 8'b0001_0000,
        S_EMIT  = 8'b0010_0000,
        S_NEXT  = 8'b0100_0000,
        S_END   = 8'b1000_0000
    } state_t;

    // pass kinds of the AES unit
    typedef enum logic [1:0] {
        P_SUBKEY = 2'd0,
        P_CIPHER = 2'd1,
        P_MAC    = 2'd2
    } pass_t;

    state_t       state_reg, state_next;
    pass_t        pass_reg, pass_next;
    logic [127:0] st_reg, st_next;
    logic [127:0] din_reg, din_next;
    logic         last_reg, last_next;
    logic [127:0] cchain_reg, cchain_next;
    logic [127:0] mchain_reg, mchain_next;
    logic [127:0] k1_reg, k1_next;
    logic         inmsg_reg, inmsg_next;
    logic [127:0] kw_reg, kw_next;     // current round key during expansion
    logic [3:0]   rnd_reg, rnd_next;   // round number, 0..10
    logic         half_reg, half_next; // key word half in memory traffic
    logic [63:0]  khi_reg, khi_next;
    logic [7:0]   rc_reg, rc_next;
    logic         ram_we;
    logic [KeyAw-1:0] ram_waddr, ram_raddr;
    logic [63:0]  ram_wdata, ram_rdata;
    logic [127:0] rk_full;
    logic [127:0] kw_step;
    logic [31:0]  tw;
    logic [127:0] pre;
    logic         emit_cipher;

    acc_key_ram u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rk_full = {khi_reg, ram_rdata};
    assign tw = sub_word({kw_reg[23:0], kw_reg[31:24]}) ^ {rc_reg, 24'd0};
    always_comb
    begin
        kw_step[127:96] = kw_reg[127:96] ^ tw;
        kw_step[95:64]  = kw_reg[95:64] ^ kw_step[127:96];
        kw_step[63:32]  = kw_reg[63:32] ^ kw_step[95:64];
        kw_step[31:0]   = kw_reg[31:0] ^ kw_step[63:32];
    end

    assign in_ready = (state_reg == S_IDLE);
    assign emit_cipher = mode[EncryptBit];

    // Sequence key expansion, round passes and result words
    always_comb
    begin
        state_next  = state_reg;
        pass_next   = pass_reg;
        st_next     = st_reg;
        din_next    = din_reg;
        last_next   = last_reg;
        cchain_next = cchain_reg;
        mchain_next = mchain_reg;
        k1_next     = k1_reg;
        inmsg_next  = inmsg_reg;
        kw_next     = kw_reg;
        rnd_next    = rnd_reg;
        half_next   = half_reg;
        khi_next    = khi_reg;
        rc_next     = rc_reg;
        ram_we      = 1'b0;
        ram_waddr   = {rnd_reg, half_reg};
        ram_wdata   = half_reg ? kw_reg[63:0] : kw_reg[127:64];
        ram_raddr   = {rnd_reg, half_reg};
        res_valid   = 1'b0;
        res.kind    = (pass_reg == P_MAC);
        res.data    = st_reg;
        res.last    = (pass_reg == P_MAC) || !mode[SignBit] || !last_reg;
        pre         = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    din_next  = in_data;
                    last_next = in_last;
                    rnd_next  = '0;
                    half_next = 1'b0;
                    if (!inmsg_reg)
                    begin
                        kw_next     = mode[EncryptBit] ? key : '0;
                        rc_next     = 8'h01;
                        cchain_next = '0;
                        mchain_next = '0;
                        inmsg_next  = 1'b1;
                        state_next  = S_KEXP;
                    end
                    else
                    begin
                        state_next = S_NEXT;
                    end
                end
            end
            // write one key half a cycle; derive the next round key after the low half
            S_KEXP:
            begin
                ram_we = 1'b1;
                half_next = ~half_reg;
                if (half_reg)
                begin
                    kw_next  = kw_step;
                    rc_next  = xtime(rc_reg);
                    rnd_next = rnd_reg + 4'd1;
                    if (rnd_reg == 4'd10)
                    begin
                        rnd_next  = '0;
                        pass_next = P_SUBKEY;
                        st_next   = '0;
                        state_next = S_LOAD;
                    end
                end
            end
            // choose the pass and set up its state, or end the word when no pass is enabled
            S_NEXT:
            begin
                rnd_next  = '0;
                half_next = 1'b0;
                if (mode[EncryptBit])
                begin
                    pass_next = P_CIPHER;
                    st_next   = din_reg ^ cchain_reg;
                    state_next = S_LOAD;
                end
                else if (mode[SignBit])
                begin
                    pass_next = P_MAC;
                    st_next   = din_reg ^ mchain_reg ^ (last_reg ? k1_reg : '0);
                    state_next = S_LOAD;
                end
                else
                begin
                    state_next = S_END;
                end
            end
            // read high half of round key
            S_LOAD:
            begin
                ram_raddr  = {rnd_reg, 1'b0};
                state_next = S_RND;
                half_next  = 1'b1;
            end
            // high half arrives and the low half is read; then the round is applied with the full key
            S_RND:
            begin
                if (half_reg)
                begin
                    khi_next  = ram_rdata;
                    ram_raddr = {rnd_reg, 1'b1};
                    half_next = 1'b0;
                end
                else
                begin
                    pre = (rnd_reg == 4'd0) ? st_reg
                                            : aes_round(st_reg, rnd_reg == 4'd10);
                    st_next = pre ^ rk_full;
                    if (rnd_reg == 4'd10)
                        state_next = S_DONE;
                    else
                    begin
                        rnd_next  = rnd_reg + 4'd1;
                        ram_raddr = {rnd_reg + 4'd1, 1'b0};
                        half_next = 1'b1;
                    end
                end
            end
            S_DONE:
            begin
                unique case (pass_reg)
                    P_SUBKEY:
                    begin
                        k1_next = {st_reg[126:0], 1'b0} ^ {120'd0, st_reg[127] ? CmacRb : 8'h00};
                        state_next = S_NEXT;
                    end
                    P_CIPHER:
                    begin
                        cchain_next = st_reg;
                        state_next  = S_EMIT;
                    end
                    P_MAC:
                    begin
                        mchain_next = st_reg;
                        state_next  = last_reg ? S_EMIT : S_END;
                    end
                    default: state_next = S_END;
                endcase
            end
            // hand out a result word, then go on with the mac pass if any
            S_EMIT:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    if (pass_reg == P_CIPHER && mode[SignBit])
                    begin
                        pass_next = P_MAC;
                        rnd_next  = '0;
                        st_next   = st_reg ^ mchain_reg ^ (last_reg ? k1_reg : '0);
                        state_next = S_LOAD;
                    end
                    else
                        state_next = S_END;
                end
            end
            S_END:
            begin
                if (last_reg)
                    inmsg_next = 1'b0;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            inmsg_reg  <= 1'b0;
            cchain_reg <= '0;
            mchain_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            inmsg_reg  <= inmsg_next;
            cchain_reg <= cchain_next;
            mchain_reg <= mchain_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        pass_reg <= pass_next;
        st_reg   <= st_next;
        din_reg  <= din_next;
        last_reg <= last_next;
        k1_reg   <= k1_next;
        kw_reg   <= kw_next;
        rnd_reg  <= rnd_next;
        half_reg <= half_next;
        khi_reg  <= khi_next;
        rc_reg   <= rc_next;
    end

    // Only the idle state takes a word
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !res_valid) else $error("ready while emitting");
    // Rounds stay in range
    a_rnd: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RND) |-> (rnd_reg <= 4'd10)) else $error("round overflow");
    // A result only leaves after a finished pass
    a_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(state_reg == S_DONE)) else $error("early result");
    // Cipher result only when encrypting
    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res.kind) |-> emit_cipher) else $error("stray cipher word");

endmodule

[src/aes_cbc_encrypt_and_cmac_sign.sv]
// Top level: APB registers, input stream, output register and the AES core.
//
// channel  | handshake            | payload
// s_axis   | tvalid/tready        | tdata {data_low,data_high}, tlast last_block
// m_axis   | tvalid/tready        | tdata {result_low,result_high}, tuser kind, tlast last_of_run
// apb      | psel/penable/pready  | key_high@0x00, key_low@0x08, mode@0x10
//
// One word at a time. An AES pass has one key fetch, two key-memory reads per round
// over the single read port and one finish state. In mode zero a word runs no pass;
// encrypt and sign runs a cipher pass and then a MAC pass. A message's first word
// adds key expansion into the key memory and the K1 pass. rst_n clears chains and
// state. A stalled output holds the core in its result state; the output register
// frees the core early.
module aes_cbc_encrypt_and_cmac_sign
    import acc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,   // data_low, data_high
    input  logic         s_axis_tlast,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [127:0] m_axis_tdata,   // result_low, result_high
    output logic         m_axis_tuser,   // kind
    output logic         m_axis_tlast,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [63:0]  pwdata,
    output logic [63:0]  prdata,
    output logic         pready
);

    typedef enum logic [1:0] {
        R_KEY_HIGH = 2'd0,
        R_KEY_LOW  = 2'd1,
        R_MODE     = 2'd2
    } reg_t;

    logic [63:0] khigh_reg, klow_reg;
    logic [1:0]  mode_reg;
    logic        wr;
    logic [1:0]  ridx;
    logic        cres_valid, cres_ready;
    res_t        cres;
    logic        ovalid_reg;
    res_t        out_reg;

    assign pready = 1'b1;
    assign ridx = paddr[4:3];
    assign wr = psel && penable && pwrite;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            khigh_reg <= '0;
            klow_reg  <= '0;
            mode_reg  <= 2'd1;
        end
        else if (wr && paddr[2:0] == 3'd0)
        begin
            unique case (ridx)
                R_KEY_HIGH: khigh_reg <= pwdata;
                R_KEY_LOW:  klow_reg  <= pwdata;
                R_MODE:     mode_reg  <= pwdata[1:0];
                default:    ;
            endcase
        end
    end

    // Register reads
    always_comb
    begin
        prdata = '0;
        if (paddr[2:0] == 3'd0)
        begin
            unique case (ridx)
                R_KEY_HIGH: prdata = khigh_reg;
                R_KEY_LOW:  prdata = klow_reg;
                R_MODE:     prdata = {62'd0, mode_reg};
                default:    prdata = '0;
            endcase
        end
    end

    acc_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .key       ({khigh_reg, klow_reg}),
        .mode      (mode_reg),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_data   ({s_axis_tdata[63:0], s_axis_tdata[127:64]}),
        .in_last   (s_axis_tlast),
        .res_valid (cres_valid),
        .res_ready (cres_ready),
        .res       (cres)
    );

    assign cres_ready = !ovalid_reg || m_axis_tready;

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ovalid_reg <= 1'b0;
        else if (cres_ready)
            ovalid_reg <= cres_valid;
    end

    always_ff @(posedge clk)
    begin
        if (cres_ready && cres_valid)
            out_reg <= cres;
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = {out_reg.data[63:0], out_reg.data[127:64]};
    assign m_axis_tuser  = out_reg.kind;
    assign m_axis_tlast  = out_reg.last;

endmodule
